[rtl/ultrasonic_echo_ranger_assert.svh]
// Assertion macros shared by the ranger RTL.
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define UER_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uer assertion failed");

// Next-cycle implication, checked out of reset.
`define UER_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uer assertion failed");

`endif

[rtl/uer_pkg.sv]
package uer_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_IDLE    = 2'd0,
        STATUS_BUSY    = 2'd1,
        STATUS_NEW     = 2'd2,
        STATUS_TIMEOUT = 2'd3
    } status_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_TIMEOUT = 2'd0,
        REG_PULSE   = 2'd1,
        REG_SPEED   = 2'd2,
        REG_OFFSET  = 2'd3
    } cfg_reg_t;

    localparam int TIMEOUT_W = 24;
    localparam int PULSE_W   = 10;
    localparam int SPEED_W   = 18;
    localparam int OFFSET_W  = 21;
    localparam int DIST_W    = 32;
    localparam int CFG_W     = 24;

    // Reset values of the configuration registers
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd30000;
    localparam logic [PULSE_W-1:0]   PULSE_RESET   = 10'd12;
    localparam logic [SPEED_W-1:0]   SPEED_RESET   = 18'd87808;
    localparam logic [OFFSET_W-1:0]  OFFSET_RESET  = 21'd0;

    // width * speed_q8 / 512, rounded half up
    localparam int ROUND_SHIFT = 9;

endpackage

[rtl/ultrasonic_echo_ranger.sv]
// Ultrasonic echo ranger: one input transfer per time-base tick.
// Throughput: one item per cycle while m_tready does not stall the output.
// Stage 1 is the tick state update, stage 2 the distance multiply, round,
// offset and saturate into the output register that drives m_*.
// Reset (rst_n, async, active low): measurement state and distance cleared,
// configuration registers return to their defaults, both pipeline stages empty.
`include "ultrasonic_echo_ranger_assert.svh"

module ultrasonic_echo_ranger
    import uer_pkg::*;
#(
    parameter int TICK_BITS = 24
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    // input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,  // [0] echo_level, [7:1] zero
    input  logic [0:0]         s_tuser,  // [0] operation (start request)
    // output stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [39:0]        m_tdata,  // [0] trigger_level, [32:1] distance_um,
                                         // [33] distance_valid, [39:34] zero
    output logic [1:0]         m_tuser   // [1:0] status
);

    localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};
    localparam int CMP_W  = (TICK_BITS > TIMEOUT_W) ? TICK_BITS : TIMEOUT_W;
    localparam int PROD_W = TICK_BITS + SPEED_W;
    localparam int RND_W  = PROD_W + 1;
    localparam int RSH_W  = RND_W - ROUND_SHIFT;
    localparam int DW     = (RSH_W + 2 > DIST_W + 2) ? RSH_W + 2 : DIST_W + 2;
    localparam logic [RND_W-1:0] ROUND_HALF = RND_W'(1) << (ROUND_SHIFT - 1);

    // Configuration registers
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [PULSE_W-1:0]   pulse_len_reg;
    logic [SPEED_W-1:0]   speed_reg;
    logic [OFFSET_W-1:0]  offset_reg;

    // Measurement state
    logic                 in_progress_reg, in_progress_next;
    logic [PULSE_W-1:0]   pulse_count_reg, pulse_count_next;
    logic [TICK_BITS-1:0] elapsed_reg, elapsed_next;
    logic [TICK_BITS-1:0] echo_start_reg, echo_start_next;
    logic                 await_fall_reg, await_fall_next;

    // Stage 1 registers
    logic                 s1_valid_reg;
    logic                 s1_trig_reg, s1_trig_next;
    status_t              s1_status_reg, s1_status_next;
    logic [TICK_BITS-1:0] s1_width_reg, s1_width_next;

    // Output register and stored result
    logic                 out_valid_reg;
    logic                 out_trig_reg;
    status_t              out_status_reg;
    logic [DIST_W-1:0]    last_dist_reg, last_dist_next;
    logic                 last_valid_reg;

    logic                 in_xfer;
    logic                 out_free;
    logic                 s1_adv;
    logic                 echo_done;

    logic [PROD_W-1:0]    prod;
    logic [RND_W-1:0]     rnd;
    logic [RSH_W-1:0]     rnd_sh;
    logic signed [DW-1:0] dist_sum;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = !s1_valid_reg || out_free;
    assign in_xfer   = s_tvalid && s_tready;
    assign s1_adv    = s1_valid_reg && out_free;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RESET;
            pulse_len_reg <= PULSE_RESET;
            speed_reg     <= SPEED_RESET;
            offset_reg    <= OFFSET_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TIMEOUT: timeout_reg   <= cfg_data[TIMEOUT_W-1:0];
                REG_PULSE:   pulse_len_reg <= cfg_data[PULSE_W-1:0];
                REG_SPEED:   speed_reg     <= cfg_data[SPEED_W-1:0];
                REG_OFFSET:  offset_reg    <= cfg_data[OFFSET_W-1:0];
                default:     ;
            endcase
        end
    end

    // Tick state update for the item at the input
    always_comb
    begin
        in_progress_next = in_progress_reg;
        pulse_count_next = pulse_count_reg;
        elapsed_next     = elapsed_reg;
        echo_start_next  = echo_start_reg;
        await_fall_next  = await_fall_reg;
        s1_trig_next     = 1'b0;
        s1_status_next   = STATUS_IDLE;
        echo_done        = 1'b0;

        if (s_tuser[0])
        begin
            in_progress_next = 1'b1;
            await_fall_next  = 1'b0;
            elapsed_next     = '0;
            echo_start_next  = '0;
            pulse_count_next = pulse_len_reg;
        end
        else if (in_progress_reg && elapsed_reg != TICK_MAX)
        begin
            elapsed_next = elapsed_reg + 1'b1;
        end

        if (in_progress_next)
        begin
            if (pulse_count_next != '0)
            begin
                s1_trig_next     = 1'b1;
                pulse_count_next = pulse_count_next - 1'b1;
                s1_status_next   = STATUS_BUSY;
            end
            else
            begin
                if (s_tdata[0])
                begin
                    if (!await_fall_next)
                    begin
                        echo_start_next = elapsed_next;
                        await_fall_next = 1'b1;
                    end
                end
                else if (await_fall_next)
                begin
                    await_fall_next  = 1'b0;
                    in_progress_next = 1'b0;
                    echo_done        = 1'b1;
                    s1_status_next   = STATUS_NEW;
                end
                // completed echo wins over timeout
                if (!echo_done)
                begin
                    if (CMP_W'(elapsed_next) >= CMP_W'(timeout_reg) ||
                        elapsed_next == TICK_MAX)
                    begin
                        in_progress_next = 1'b0;
                        await_fall_next  = 1'b0;
                        s1_status_next   = STATUS_TIMEOUT;
                    end
                    else
                    begin
                        s1_status_next = STATUS_BUSY;
                    end
                end
            end
        end

        s1_width_next = elapsed_next - echo_start_next;
    end

    // Measurement state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_progress_reg <= 1'b0;
            pulse_count_reg <= '0;
            elapsed_reg     <= '0;
            echo_start_reg  <= '0;
            await_fall_reg  <= 1'b0;
        end
        else if (in_xfer)
        begin
            in_progress_reg <= in_progress_next;
            pulse_count_reg <= pulse_count_next;
            elapsed_reg     <= elapsed_next;
            echo_start_reg  <= echo_start_next;
            await_fall_reg  <= await_fall_next;
        end
    end

    // Stage 1 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_trig_reg   <= s1_trig_next;
            s1_status_reg <= s1_status_next;
            s1_width_reg  <= s1_width_next;
        end
    end

    // Distance: round(width * speed / 512) + offset, saturated to 32 bits
    always_comb
    begin
        prod     = PROD_W'(s1_width_reg) * PROD_W'(speed_reg);
        rnd      = {1'b0, prod} + ROUND_HALF;
        rnd_sh   = rnd[RND_W-1:ROUND_SHIFT];
        dist_sum = $signed({{(DW-RSH_W){1'b0}}, rnd_sh})
                 + $signed({{(DW-OFFSET_W){offset_reg[OFFSET_W-1]}}, offset_reg});
        if (dist_sum[DW-1])
        begin
            last_dist_next = '0;
        end
        else if (|dist_sum[DW-2:DIST_W])
        begin
            last_dist_next = '1;
        end
        else
        begin
            last_dist_next = dist_sum[DIST_W-1:0];
        end
    end

    // Output register and stored distance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            out_trig_reg   <= 1'b0;
            out_status_reg <= STATUS_IDLE;
            last_dist_reg  <= '0;
            last_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_adv)
            begin
                out_trig_reg   <= s1_trig_reg;
                out_status_reg <= s1_status_reg;
                if (s1_status_reg == STATUS_NEW)
                begin
                    last_dist_reg  <= last_dist_next;
                    last_valid_reg <= 1'b1;
                end
                else if (s1_status_reg == STATUS_TIMEOUT)
                begin
                    last_valid_reg <= 1'b0;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {6'd0, last_valid_reg, last_dist_reg, out_trig_reg};

    // Checks
    `UER_ASSERT_NOW(a_trig_busy, out_valid_reg && out_trig_reg, out_status_reg == STATUS_BUSY)
    `UER_ASSERT_NOW(a_new_valid, out_valid_reg && out_status_reg == STATUS_NEW, last_valid_reg)
    `UER_ASSERT_NOW(a_tmo_invalid, out_valid_reg && out_status_reg == STATUS_TIMEOUT, !last_valid_reg)
    `UER_ASSERT_NOW(a_pulse_running, pulse_count_reg != '0, in_progress_reg)
    `UER_ASSERT_NEXT(a_fall_running, in_xfer && await_fall_next, in_progress_reg)

endmodule

[dv/ranger_scoreboard_pkg.sv]
package ranger_scoreboard_pkg;
    import uer_pkg::*;

    // Tick counter width, matches the default TICK_BITS of the ranger
    localparam int TICK_W = 24;

    // One output reading of the ranger
    typedef struct packed {
        logic              trigger;
        status_t           status;
        logic [DIST_W-1:0] distance;
        logic              valid;
    } ranger_reading_t;

    class ranger_scoreboard;
        // register copy
        logic [TIMEOUT_W-1:0]       timeout_ticks;
        logic [PULSE_W-1:0]         pulse_ticks;
        logic [SPEED_W-1:0]         speed_q8;
        logic signed [OFFSET_W-1:0] offset_um;

        // measurement state
        bit                 measuring;
        logic [PULSE_W-1:0] pulse_left;
        logic [TICK_W-1:0]  elapsed;
        logic [TICK_W-1:0]  echo_rise;
        bit                 awaiting_fall;
        logic [DIST_W-1:0]  distance;
        bit                 distance_ok;

        ranger_reading_t expected_readings[$];
        int errors;
        int completions;
        int timeouts;

        function new();
            timeout_ticks = TIMEOUT_RESET;
            pulse_ticks   = PULSE_RESET;
            speed_q8      = SPEED_RESET;
            offset_um     = OFFSET_RESET;
            measuring     = 1'b0;
            pulse_left    = '0;
            elapsed       = '0;
            echo_rise     = '0;
            awaiting_fall = 1'b0;
            distance      = '0;
            distance_ok   = 1'b0;
            errors        = 0;
            completions   = 0;
            timeouts      = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_TIMEOUT: timeout_ticks = data[TIMEOUT_W-1:0];
                REG_PULSE:   pulse_ticks   = data[PULSE_W-1:0];
                REG_SPEED:   speed_q8      = data[SPEED_W-1:0];
                REG_OFFSET:  offset_um     = data[OFFSET_W-1:0];
                default: ;
            endcase
        endfunction

        // width * speed / 512, rounded half up, offset added, clamped to 32 bits
        function logic [DIST_W-1:0] echo_distance(logic [TICK_W-1:0] width);
            longint scaled;
            scaled = longint'(width) * longint'(speed_q8);
            scaled = ((scaled + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT)
                     + longint'(offset_um);
            if (scaled < 0)
                return '0;
            if (scaled > longint'(32'hFFFF_FFFF))
                return '1;
            return scaled[DIST_W-1:0];
        endfunction

        // Advance the ranger by one accepted tick and queue the reading it gives
        function void note_tick(bit start, bit echo);
            ranger_reading_t r;
            bit finished;
            r.trigger = 1'b0;
            r.status  = STATUS_IDLE;
            finished  = 1'b0;

            if (start)
            begin
                measuring     = 1'b1;
                awaiting_fall = 1'b0;
                elapsed       = '0;
                echo_rise     = '0;
                pulse_left    = pulse_ticks;
            end
            else if (measuring && elapsed != '1)
            begin
                elapsed = elapsed + 1'b1;
            end

            if (measuring)
            begin
                if (pulse_left != '0)
                begin
                    // trigger pulse, echo ignored, no timeout check yet
                    r.trigger  = 1'b1;
                    pulse_left = pulse_left - 1'b1;
                    r.status   = STATUS_BUSY;
                end
                else
                begin
                    if (echo)
                    begin
                        if (!awaiting_fall)
                        begin
                            echo_rise     = elapsed;
                            awaiting_fall = 1'b1;
                        end
                    end
                    else if (awaiting_fall)
                    begin
                        awaiting_fall = 1'b0;
                        distance      = echo_distance(elapsed - echo_rise);
                        distance_ok   = 1'b1;
                        measuring     = 1'b0;
                        finished      = 1'b1;
                        r.status      = STATUS_NEW;
                        completions++;
                    end
                    // a completed echo beats a timeout on the same tick
                    if (!finished)
                    begin
                        if (elapsed >= timeout_ticks || elapsed == '1)
                        begin
                            distance_ok   = 1'b0;
                            measuring     = 1'b0;
                            awaiting_fall = 1'b0;
                            r.status      = STATUS_TIMEOUT;
                            timeouts++;
                        end
                        else
                        begin
                            r.status = STATUS_BUSY;
                        end
                    end
                end
            end

            r.distance = distance;
            r.valid    = distance_ok;
            expected_readings.push_back(r);
        endfunction

        function void check_reading(ranger_reading_t got);
            ranger_reading_t want;
            if (expected_readings.size() == 0)
            begin
                $error("reading with none expected: trig %0d code %0d dist %0d valid %0d",
                       got.trigger, got.status, got.distance, got.valid);
                errors++;
                return;
            end
            want = expected_readings.pop_front();
            if (got.trigger !== want.trigger)
            begin
                $error("trigger_level expected %0d actual %0d", want.trigger, got.trigger);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status expected %0d actual %0d", want.status, got.status);
                errors++;
            end
            if (got.distance !== want.distance)
            begin
                $error("distance_um expected %0d actual %0d", want.distance, got.distance);
                errors++;
            end
            if (got.valid !== want.valid)
            begin
                $error("distance_valid expected %0d actual %0d", want.valid, got.valid);
                errors++;
            end
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction
    endclass

endpackage

[dv/tb.sv]
module tb;
    import uer_pkg::*;
    import ranger_scoreboard_pkg::*;

    localparam int ITEM_TARGET  = 1100;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 120;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;   // [0] echo_level, [7:1] zero
    logic [0:0]         s_tuser;   // [0] operation
    logic               m_tvalid;
    logic               m_tready;
    logic [39:0]        m_tdata;   // [0] trigger_level, [32:1] distance_um,
                                   // [33] distance_valid, [39:34] zero
    logic [1:0]         m_tuser;   // [1:0] status

    ranger_scoreboard sb;

    int ticks_sent;
    int readings_taken;
    int writes_done;
    int idle_cycles;
    int settings_used;
    bit gaps_on;
    int hold_request;
    logic [TIMEOUT_W-1:0] cur_timeout;
    logic [PULSE_W-1:0]   cur_pulse;

    ultrasonic_echo_ranger dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 10 unit clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Transfer monitor: register writes, ticks in, readings out
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
                writes_done++;
            end
            if (s_tvalid && s_tready)
            begin
                sb.note_tick(s_tuser[0], s_tdata[0]);
                ticks_sent++;
            end
            if (m_tvalid && m_tready)
            begin
                sb.check_reading('{trigger:  m_tdata[0],
                                   status:   status_t'(m_tuser),
                                   distance: m_tdata[32:1],
                                   valid:    m_tdata[33]});
                readings_taken++;
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (cfg_valid && cfg_ready) || (s_tvalid && s_tready)
            || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Reading sink: random stalls, plus one long hold-off on request
    initial
    begin : reading_sink
        int stall;
        int seen;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = gaps_on ? $urandom_range(0, 3) : 0;
            stall += hold_request;
            hold_request = 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            seen = readings_taken;
            do @(negedge clk); while (readings_taken == seen);
        end
    end

    // One tick transfer, with an optional gap ahead of it
    task automatic send_tick(bit start, bit echo);
        int gap;
        int seen;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= start;
        s_tdata  <= {7'b0, echo};
        seen = ticks_sent;
        do @(negedge clk); while (ticks_sent == seen);
    endtask

    // Stop ticks and wait until every reading has come back
    task automatic drain_readings();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
    endtask

    task automatic write_one(cfg_reg_t idx, logic [CFG_W-1:0] data);
        int seen;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        seen = writes_done;
        do @(negedge clk); while (writes_done == seen);
    endtask

    // New setting, written only after all pending readings have drained
    task automatic program_ranger(logic [TIMEOUT_W-1:0] t, logic [PULSE_W-1:0] p,
                                  logic [SPEED_W-1:0] s, logic signed [OFFSET_W-1:0] o);
        drain_readings();
        write_one(REG_TIMEOUT, CFG_W'(t));
        write_one(REG_PULSE, CFG_W'(p));
        write_one(REG_SPEED, CFG_W'(s));
        write_one(REG_OFFSET, {{(CFG_W - OFFSET_W){1'b0}}, o});
        cfg_valid <= 1'b0;
        cur_timeout = t;
        cur_pulse   = p;
        settings_used++;
    endtask

    // One ranging cycle: start, trigger pulse, planned echo, then a short idle tail.
    // Kinds: mostly clean echoes, echo ending right at the timeout, no echo,
    // restart midway, and noisy echo.
    task automatic run_ranging();
        int kind;
        int delay_t;
        int width_t;
        int restart_at;
        int cap;
        int e;
        int j;
        bit op;
        bit lvl;
        kind       = $urandom_range(0, 9);
        delay_t    = $urandom_range(0, 30);
        width_t    = $urandom_range(1, 50);
        restart_at = -1;
        if (kind == 6 && cur_timeout > cur_pulse + 1 && cur_timeout - cur_pulse <= 80)
        begin
            width_t = $urandom_range(1, cur_timeout - cur_pulse);
            delay_t = cur_timeout - cur_pulse - width_t;
        end
        if (kind == 8)
            restart_at = $urandom_range(1, cur_pulse + delay_t + 2);
        cap = cur_pulse + delay_t + width_t + 3;
        if (kind == 7)
        begin
            width_t = 0;
            if (cur_timeout <= 400)
                cap = cur_pulse + cur_timeout + 3;
        end

        e  = 0;
        op = 1'b1;
        do
        begin
            if (e < cur_pulse)
            begin
                lvl = 1'($urandom_range(0, 1));
            end
            else
            begin
                j   = e - cur_pulse;
                lvl = (j >= delay_t) && (j < delay_t + width_t);
            end
            if (kind == 9 && $urandom_range(0, 3) == 0)
                lvl = !lvl;
            send_tick(op, lvl);
            op = 1'b0;
            e++;
            if (e == restart_at)
            begin
                op         = 1'b1;
                e          = 0;
                restart_at = -1;
            end
        end
        while (sb.measuring && e < cap);

        repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin : stimulus
        int phase;
        int sel;
        int small_off;
        logic [TIMEOUT_W-1:0]       t;
        logic [PULSE_W-1:0]         p;
        logic [SPEED_W-1:0]         s;
        logic signed [OFFSET_W-1:0] o;

        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_TIMEOUT;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        ticks_sent     = 0;
        readings_taken = 0;
        writes_done    = 0;
        idle_cycles    = 0;
        settings_used  = 0;
        gaps_on        = 1'b1;
        hold_request   = 0;
        cur_timeout    = TIMEOUT_RESET;
        cur_pulse      = PULSE_RESET;
        sb             = new();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset setting, idle echo ignored, echo during pulse ignored
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        for (int i = 0; i < 11; i++)
            send_tick(1'b0, i[0]);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);

        // zero pulse and zero timeout: timeout on the start tick itself
        program_ranger('0, '0, 18'd256, 21'sd1048575);
        send_tick(1'b1, 1'b1);

        // odd width rounds half up; echo end on the timeout tick wins
        program_ranger(24'd5, '0, 18'd256, 21'sd1048575);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);

        // Largest timeout, speed and offset in one setting
        program_ranger('1, PULSE_W'(1), '1, 21'sd1048575);
        run_ranging();

        // Random settings, several ranging cycles each
        phase = 0;
        while (ticks_sent < ITEM_TARGET)
        begin
            sel = $urandom_range(0, 7);
            t = (sel == 0) ? '0 : (sel == 1) ? '1 : TIMEOUT_W'($urandom_range(1, 250));
            sel = $urandom_range(0, 5);
            p = (sel == 0) ? '0 : (sel == 1) ? PULSE_W'(1) : PULSE_W'($urandom_range(2, 12));
            sel = $urandom_range(0, 5);
            case (sel)
                0:       s = '0;
                1:       s = SPEED_W'(1);
                2:       s = SPEED_W'(256);
                3:       s = '1;
                default: s = SPEED_W'($urandom);
            endcase
            sel = $urandom_range(0, 4);
            small_off = $urandom_range(0, 4000) - 2000;
            case (sel)
                0:       o = 21'sh100000;
                1:       o = 21'sd1048575;
                2:       o = OFFSET_W'(small_off);
                3:       o = OFFSET_W'($urandom);
                default: o = '0;
            endcase
            program_ranger(t, p, s, o);

            gaps_on = (phase % 3) != 2;
            if (phase == 1)
            begin
                // long sink hold-off with the source pushing back to back
                gaps_on      = 1'b0;
                hold_request = HOLD_CYCLES;
            end
            repeat (6) run_ranging();
            phase++;
        end

        drain_readings();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("ranger run: %0d ticks and %0d readings, %0d echoes ranged, %0d timeouts",
                 ticks_sent, readings_taken, sb.completions, sb.timeouts);
        $display("ranger run: %0d settings incl. top timeout/speed/offset, zero pulse, zero timeout",
                 settings_used);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[ultrasonic_echo_ranger.f]
+incdir+rtl
rtl/uer_pkg.sv
rtl/ultrasonic_echo_ranger.sv
dv/ranger_scoreboard_pkg.sv
dv/tb.sv
